// File: sv/tmp_pkg.sv
// Shared types and constants for the trapezoidal motion profile block.
// Used by tmp_unit, tmp_ctrl and trapezoidal_motion_profile; no dependencies.
package tmp_pkg;

    localparam int VALUE_WIDTH_DEF   = 32;
    localparam int FRACTION_BITS_DEF = 16;

    // The triangle scale factor is an unsigned Q0.30 square root.
    localparam int SCALE_BITS = 30;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_RATE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DECEL_RATE  = 2'd2;

    localparam logic ACT_PLAN   = 1'b0;
    localparam logic ACT_SAMPLE = 1'b1;

    typedef enum logic [1:0] {
        OP_MUL,
        OP_DIV,
        OP_SQRT
    } t_op;

    typedef struct packed {
        logic start;
        t_op  op;
    } t_unit_req;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DIST,
        ST_CHECK,
        ST_TU,
        ST_TD,
        ST_VV,
        ST_R1,
        ST_R2,
        ST_CMP,
        ST_TC,
        ST_Q,
        ST_SQ,
        ST_MU,
        ST_MD,
        ST_PK,
        ST_SUM,
        ST_S0,
        ST_S1,
        ST_A1,
        ST_A2,
        ST_B1,
        ST_B2,
        ST_FAR,
        ST_POS,
        ST_OUT
    } t_state;

endpackage

// File: sv/trapezoidal_motion_profile.sv
// Trapezoidal motion profile: a plan word runs divides, multiplies and, for a
// triangle profile, a square root on the shared unit; a sample word at the ends
// of the move skips the unit, and one inside the move may use it.
// One word is in work at a time; the next is taken once the result is loaded.
// The shared unit retires one bit per cycle. Synchronous active-low reset clears
// the config registers, the profile valid flag and total, and the output valid.
module trapezoidal_motion_profile #(
    parameter int VALUE_WIDTH   = tmp_pkg::VALUE_WIDTH_DEF,
    parameter int FRACTION_BITS = tmp_pkg::FRACTION_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [tmp_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [VALUE_WIDTH-1:0]          i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_action,
    input  logic signed [VALUE_WIDTH-1:0]   i_start_position,
    input  logic signed [VALUE_WIDTH-1:0]   i_target_position,
    input  logic [VALUE_WIDTH-1:0]          i_elapsed_time,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic signed [VALUE_WIDTH-1:0]   o_position,
    output logic                            o_profile_valid,
    output logic [VALUE_WIDTH-1:0]          o_move_time,
    output logic                            o_move_done
);
    import tmp_pkg::*;

    logic [VALUE_WIDTH-1:0] r_speed_limit;
    logic [VALUE_WIDTH-1:0] r_accel_rate;
    logic [VALUE_WIDTH-1:0] r_decel_rate;
    logic [VALUE_WIDTH-1:0] position;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed_limit <= '0;
            r_accel_rate  <= '0;
            r_decel_rate  <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SPEED_LIMIT: r_speed_limit <= i_cfg_data;
                CFG_ACCEL_RATE:  r_accel_rate  <= i_cfg_data;
                CFG_DECEL_RATE:  r_decel_rate  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    tmp_ctrl #(
        .VALUE_WIDTH  (VALUE_WIDTH),
        .FRACTION_BITS(FRACTION_BITS)
    ) u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_speed_limit    (r_speed_limit),
        .i_accel_rate     (r_accel_rate),
        .i_decel_rate     (r_decel_rate),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_action         (i_action),
        .i_start_position (i_start_position),
        .i_target_position(i_target_position),
        .i_elapsed_time   (i_elapsed_time),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_position       (position),
        .o_profile_valid  (o_profile_valid),
        .o_move_time      (o_move_time),
        .o_move_done      (o_move_done)
    );

    assign o_position = $signed(position);

endmodule

// File: sv/tmp_unit.sv
// Shared bit-serial arithmetic unit: shift-add multiply, restoring divide
// and digit-by-digit square root, one bit per cycle. Depends on tmp_pkg.
module tmp_unit #(
    parameter int VALUE_WIDTH = tmp_pkg::VALUE_WIDTH_DEF
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  tmp_pkg::t_unit_req                            i_req,
    input  logic [VALUE_WIDTH+2*tmp_pkg::SCALE_BITS-1:0]  i_a,
    input  logic [VALUE_WIDTH+2*tmp_pkg::SCALE_BITS-1:0]  i_b,
    output logic                                          o_done,
    output logic [VALUE_WIDTH+2*tmp_pkg::SCALE_BITS-1:0]  o_result
);
    import tmp_pkg::*;

    localparam int S  = SCALE_BITS;
    localparam int NW = VALUE_WIDTH + 2 * S;
    localparam int MB = VALUE_WIDTH + 1;
    localparam int CW = $clog2(NW + 1);

    logic          r_busy, n_busy;
    logic          r_done, n_done;
    t_op           r_op, n_op;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [NW:0]   r_acc, n_acc;
    logic [NW-1:0] r_q, n_q;
    logic [NW-1:0] r_d, n_d;
    logic [S-1:0]  r_root, n_root;

    logic [NW-1:0] mul_sum;
    logic [NW:0]   div_sh;
    logic [NW+1:0] div_diff;
    logic [S+2:0]  sq_sh;
    logic [S+3:0]  sq_diff;

    always_comb begin
        mul_sum  = {r_acc[NW-2:0], 1'b0} + (r_q[MB-1] ? r_d : '0);
        div_sh   = {r_acc[NW-1:0], r_q[NW-1]};
        div_diff = {1'b0, div_sh} - {2'b00, r_d};
        sq_sh    = {r_acc[S:0], r_q[2*S-1:2*S-2]};
        sq_diff  = {1'b0, sq_sh} - {2'b00, r_root, 2'b01};

        n_busy = r_busy;
        n_done = 1'b0;
        n_op   = r_op;
        n_cnt  = r_cnt;
        n_acc  = r_acc;
        n_q    = r_q;
        n_d    = r_d;
        n_root = r_root;

        if (i_req.start && !r_busy) begin
            n_busy = 1'b1;
            n_op   = i_req.op;
            n_acc  = '0;
            n_root = '0;
            case (i_req.op)
                OP_MUL: begin
                    n_d   = i_a;
                    n_q   = i_b;
                    n_cnt = CW'(MB);
                end
                OP_DIV: begin
                    n_d   = i_b;
                    n_q   = i_a;
                    n_cnt = CW'(NW);
                end
                OP_SQRT: begin
                    n_q   = i_a;
                    n_cnt = CW'(S);
                end
                default: begin
                    n_busy = 1'b0;
                end
            endcase
        end else if (r_busy) begin
            case (r_op)
                OP_MUL: begin
                    n_acc = {1'b0, mul_sum};
                    n_q   = {r_q[NW-2:0], 1'b0};
                end
                OP_DIV: begin
                    if (!div_diff[NW+1]) begin
                        n_acc = div_diff[NW:0];
                        n_q   = {r_q[NW-2:0], 1'b1};
                    end else begin
                        n_acc = div_sh;
                        n_q   = {r_q[NW-2:0], 1'b0};
                    end
                end
                OP_SQRT: begin
                    n_q = {r_q[NW-3:0], 2'b00};
                    if (!sq_diff[S+3]) begin
                        n_acc  = (NW+1)'(sq_diff[S:0]);
                        n_root = {r_root[S-2:0], 1'b1};
                    end else begin
                        n_acc  = (NW+1)'(sq_sh[S:0]);
                        n_root = {r_root[S-2:0], 1'b0};
                    end
                end
                default: ;
            endcase
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_op   <= OP_MUL;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_op   <= n_op;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt  <= n_cnt;
        r_acc  <= n_acc;
        r_q    <= n_q;
        r_d    <= n_d;
        r_root <= n_root;
    end

    always_comb begin
        case (r_op)
            OP_MUL:  o_result = r_acc[NW-1:0];
            OP_DIV:  o_result = r_q;
            OP_SQRT: o_result = NW'(r_root);
            default: o_result = '0;
        endcase
    end

    assign o_done = r_done;

`ifndef SYNTHESIS
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_busy) else $error("unit started while busy");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy) else $error("unit done while busy");
    a_last_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_cnt == CW'(1)) |=> r_done) else $error("unit missed done");
`endif

endmodule

// File: sv/tmp_ctrl.sv
// Sequencer for planning and sampling: holds the profile, drives the shared
// unit and the output register. Depends on tmp_pkg and tmp_unit.
module tmp_ctrl #(
    parameter int VALUE_WIDTH   = tmp_pkg::VALUE_WIDTH_DEF,
    parameter int FRACTION_BITS = tmp_pkg::FRACTION_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic [VALUE_WIDTH-1:0]  i_speed_limit,
    input  logic [VALUE_WIDTH-1:0]  i_accel_rate,
    input  logic [VALUE_WIDTH-1:0]  i_decel_rate,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic                    i_action,
    input  logic [VALUE_WIDTH-1:0]  i_start_position,
    input  logic [VALUE_WIDTH-1:0]  i_target_position,
    input  logic [VALUE_WIDTH-1:0]  i_elapsed_time,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic [VALUE_WIDTH-1:0]  o_position,
    output logic                    o_profile_valid,
    output logic [VALUE_WIDTH-1:0]  o_move_time,
    output logic                    o_move_done
);
    import tmp_pkg::*;

    localparam int W  = VALUE_WIDTH;
    localparam int F  = FRACTION_BITS;
    localparam int S  = SCALE_BITS;
    localparam int NW = W + 2 * S;

    t_state        r_state, n_state;
    logic [W-1:0]  r_start, n_start;
    logic [W-1:0]  r_target, n_target;
    logic [W-1:0]  r_dist, n_dist;
    logic          r_dir, n_dir;
    logic [W-1:0]  r_tu, n_tu;
    logic [W-1:0]  r_tc, n_tc;
    logic [W-1:0]  r_td, n_td;
    logic [W-1:0]  r_pk, n_pk;
    logic [W-1:0]  r_total, n_total;
    logic          r_valid, n_valid;
    logic [NW-1:0] r_ramps, n_ramps;
    logic [NW-1:0] r_tmp, n_tmp;
    logic [W-1:0]  r_t, n_t;
    logic [W:0]    r_y, n_y;
    logic [W-1:0]  r_mv, n_mv;
    logic [W-1:0]  r_pos, n_pos;
    logic          r_md, n_md;
    logic          r_out_valid, n_out_valid;
    logic [W-1:0]  r_o_pos, n_o_pos;
    logic          r_o_pv, n_o_pv;
    logic [W-1:0]  r_o_mt, n_o_mt;
    logic          r_o_md, n_o_md;

    t_unit_req     u_req;
    logic [NW-1:0] u_a, u_b, u_res;
    logic          u_done;

    logic [W:0]    diff;
    logic [W:0]    sum_utc;
    logic [W+1:0]  sum3;
    logic [NW-1:0] far;
    logic [W-1:0]  rr;
    logic [W:0]    xb;

    function automatic logic [W-1:0] f_cap(input logic [NW-1:0] x);
        f_cap = (|x[NW-1:W]) ? '1 : x[W-1:0];
    endfunction

    tmp_unit #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_unit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (u_req),
        .i_a     (u_a),
        .i_b     (u_b),
        .o_done  (u_done),
        .o_result(u_res)
    );

    always_comb begin
        n_state = r_state;   n_start = r_start;   n_target = r_target;
        n_dist = r_dist;     n_dir = r_dir;       n_tu = r_tu;
        n_tc = r_tc;         n_td = r_td;         n_pk = r_pk;
        n_total = r_total;   n_valid = r_valid;   n_ramps = r_ramps;
        n_tmp = r_tmp;       n_t = r_t;           n_y = r_y;
        n_mv = r_mv;         n_pos = r_pos;       n_md = r_md;
        n_out_valid = r_out_valid;
        n_o_pos = r_o_pos;   n_o_pv = r_o_pv;     n_o_mt = r_o_mt;
        n_o_md = r_o_md;

        u_req.start = 1'b0;
        u_req.op    = OP_MUL;
        u_a         = '0;
        u_b         = '0;

        diff    = {r_target[W-1], r_target} - {r_start[W-1], r_start};
        sum_utc = {1'b0, r_tu} + {1'b0, r_tc};
        sum3    = {2'b00, r_tu} + {2'b00, r_tc} + {2'b00, r_td};
        far     = u_res >> (F + 1);
        rr      = r_t - sum_utc[W-1:0];
        xb      = r_y - u_res[W:0];

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_action == ACT_PLAN) begin
                        n_start  = i_start_position;
                        n_target = i_target_position;
                        n_state  = ST_DIST;
                    end else begin
                        n_t     = i_elapsed_time;
                        n_state = ST_S0;
                    end
                end
            end
            ST_DIST: begin
                n_dir   = diff[W];
                n_dist  = diff[W] ? (~diff[W-1:0] + 1'b1) : diff[W-1:0];
                n_tu    = '0;
                n_tc    = '0;
                n_td    = '0;
                n_pk    = '0;
                n_total = '0;
                n_valid = 1'b0;
                n_pos   = r_start;
                n_md    = 1'b0;
                n_state = ST_CHECK;
            end
            ST_CHECK: begin
                if (i_speed_limit == '0 || i_accel_rate == '0 || i_decel_rate == '0 ||
                    r_dist == '0) begin
                    n_state = ST_OUT;
                end else begin
                    u_req.start = 1'b1;
                    u_req.op    = OP_DIV;
                    u_a         = NW'(i_speed_limit) << F;
                    u_b         = NW'(i_accel_rate);
                    n_state     = ST_TU;
                end
            end
            ST_TU: begin
                if (u_done) begin
                    n_tu        = f_cap(u_res);
                    u_req.start = 1'b1;
                    u_req.op    = OP_DIV;
                    u_a         = NW'(i_speed_limit) << F;
                    u_b         = NW'(i_decel_rate);
                    n_state     = ST_TD;
                end
            end
            ST_TD: begin
                if (u_done) begin
                    n_td        = f_cap(u_res);
                    u_req.start = 1'b1;
                    u_req.op    = OP_MUL;
                    u_a         = NW'(i_speed_limit);
                    u_b         = NW'(i_speed_limit);
                    n_state     = ST_VV;
                end
            end
            ST_VV: begin
                if (u_done) begin
                    n_tmp       = u_res;
                    u_req.start = 1'b1;
                    u_req.op    = OP_DIV;
                    u_a         = u_res;
                    u_b         = NW'({i_accel_rate, 1'b0});
                    n_state     = ST_R1;
                end
            end
            ST_R1: begin
                if (u_done) begin
                    n_ramps     = u_res;
                    u_req.start = 1'b1;
                    u_req.op    = OP_DIV;
                    u_a         = r_tmp;
                    u_b         = NW'({i_decel_rate, 1'b0});
                    n_state     = ST_R2;
                end
            end
            ST_R2: begin
                if (u_done) begin
                    n_ramps = r_ramps + u_res;
                    n_state = ST_CMP;
                end
            end
            ST_CMP: begin
                u_req.start = 1'b1;
                u_req.op    = OP_DIV;
                if (NW'(r_dist) >= r_ramps) begin
                    // Full speed is reached: cruise covers what the ramps leave.
                    n_pk    = i_speed_limit;
                    u_a     = NW'(r_dist - r_ramps[W-1:0]) << F;
                    u_b     = NW'(i_speed_limit);
                    n_state = ST_TC;
                end else begin
                    u_a     = {r_dist, {(2*S){1'b0}}};
                    u_b     = r_ramps;
                    n_state = ST_Q;
                end
            end
            ST_TC: begin
                if (u_done) begin
                    n_tc    = f_cap(u_res);
                    n_state = ST_SUM;
                end
            end
            ST_Q: begin
                if (u_done) begin
                    u_req.start = 1'b1;
                    u_req.op    = OP_SQRT;
                    u_a         = u_res;
                    n_state     = ST_SQ;
                end
            end
            ST_SQ: begin
                if (u_done) begin
                    n_tmp       = u_res;
                    u_req.start = 1'b1;
                    u_req.op    = OP_MUL;
                    u_a         = u_res;
                    u_b         = NW'(r_tu);
                    n_state     = ST_MU;
                end
            end
            ST_MU: begin
                if (u_done) begin
                    n_tu        = u_res[W+S-1:S];
                    u_req.start = 1'b1;
                    u_req.op    = OP_MUL;
                    u_a         = r_tmp;
                    u_b         = NW'(r_td);
                    n_state     = ST_MD;
                end
            end
            ST_MD: begin
                if (u_done) begin
                    n_td        = u_res[W+S-1:S];
                    u_req.start = 1'b1;
                    u_req.op    = OP_MUL;
                    u_a         = NW'(i_accel_rate);
                    u_b         = NW'(r_tu);
                    n_state     = ST_PK;
                end
            end
            ST_PK: begin
                if (u_done) begin
                    n_pk    = f_cap(u_res >> F);
                    n_tc    = '0;
                    n_state = ST_SUM;
                end
            end
            ST_SUM: begin
                n_total = (|sum3[W+1:W]) ? '1 : sum3[W-1:0];
                n_valid = 1'b1;
                n_state = ST_OUT;
            end
            ST_S0: begin
                n_y  = {r_t, 1'b0} - {1'b0, r_tu};
                n_md = r_valid && (r_t >= r_total);
                if (!r_valid || r_t == '0) begin
                    n_pos   = r_start;
                    n_state = ST_OUT;
                end else if (r_t >= r_total) begin
                    n_pos   = r_target;
                    n_state = ST_OUT;
                end else if (r_t < r_tu) begin
                    u_req.start = 1'b1;
                    u_req.op    = OP_MUL;
                    u_a         = NW'(r_t);
                    u_b         = NW'(r_t);
                    n_state     = ST_A1;
                end else begin
                    n_state = ST_S1;
                end
            end
            ST_S1: begin
                if ({1'b0, r_t} < sum_utc) begin
                    // Cruise distance is peak * (2t - tu) / 2.
                    u_req.start = 1'b1;
                    u_req.op    = OP_MUL;
                    u_a         = NW'(r_pk);
                    u_b         = NW'(r_y);
                    n_state     = ST_FAR;
                end else if (r_td != '0) begin
                    u_req.start = 1'b1;
                    u_req.op    = OP_MUL;
                    u_a         = NW'(rr);
                    u_b         = NW'(rr);
                    n_state     = ST_B1;
                end else begin
                    n_pos   = r_target;
                    n_state = ST_OUT;
                end
            end
            ST_A1: begin
                if (u_done) begin
                    u_req.start = 1'b1;
                    u_req.op    = OP_DIV;
                    u_a         = u_res;
                    u_b         = NW'(r_tu);
                    n_state     = ST_A2;
                end
            end
            ST_A2: begin
                if (u_done) begin
                    u_req.start = 1'b1;
                    u_req.op    = OP_MUL;
                    u_a         = NW'(r_pk);
                    u_b         = NW'(u_res[W-1:0]);
                    n_state     = ST_FAR;
                end
            end
            ST_B1: begin
                if (u_done) begin
                    u_req.start = 1'b1;
                    u_req.op    = OP_DIV;
                    u_a         = u_res;
                    u_b         = NW'(r_td);
                    n_state     = ST_B2;
                end
            end
            ST_B2: begin
                if (u_done) begin
                    // Ramp-down distance is peak * (2t - tu - r*r/td) / 2.
                    u_req.start = 1'b1;
                    u_req.op    = OP_MUL;
                    u_a         = NW'(r_pk);
                    u_b         = NW'(xb);
                    n_state     = ST_FAR;
                end
            end
            ST_FAR: begin
                if (u_done) begin
                    n_mv    = (far > NW'(r_dist)) ? r_dist : far[W-1:0];
                    n_state = ST_POS;
                end
            end
            ST_POS: begin
                n_pos   = r_dir ? (r_start - r_mv) : (r_start + r_mv);
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_o_pos     = r_pos;
                    n_o_pv      = r_valid;
                    n_o_mt      = r_total;
                    n_o_md      = r_md;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_valid     <= 1'b0;
            r_start     <= '0;
            r_total     <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_valid     <= n_valid;
            r_start     <= n_start;
            r_total     <= n_total;
        end
    end

    always_ff @(posedge i_clk) begin
        r_target <= n_target;
        r_dist   <= n_dist;
        r_dir    <= n_dir;
        r_tu     <= n_tu;
        r_tc     <= n_tc;
        r_td     <= n_td;
        r_pk     <= n_pk;
        r_ramps  <= n_ramps;
        r_tmp    <= n_tmp;
        r_t      <= n_t;
        r_y      <= n_y;
        r_mv     <= n_mv;
        r_pos    <= n_pos;
        r_md     <= n_md;
        r_o_pos  <= n_o_pos;
        r_o_pv   <= n_o_pv;
        r_o_mt   <= n_o_mt;
        r_o_md   <= n_o_md;
    end

    assign o_in_ready      = (r_state == ST_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_position      = r_o_pos;
    assign o_profile_valid = r_o_pv;
    assign o_move_time     = r_o_mt;
    assign o_move_done     = r_o_md;

`ifndef SYNTHESIS
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && i_in_valid) |=> (r_state != ST_IDLE))
        else $error("accepted word did not start work");
    a_sum_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SUM) |=> r_valid) else $error("finished plan not valid");
    a_zero_dist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CHECK && r_dist == '0) |=> !r_valid)
        else $error("zero distance gave a valid plan");
`endif

endmodule
